// ===== rtl/core/sts_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the sorted table binary search block.
// ----------------------------------------------------------------------------
package sts_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);

    // field widths
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int VAL_W  = 32;

    // packed stream widths, rounded up to whole bytes
    localparam int IN_BITS   = IDX_W + VAL_W + VAL_W;
    localparam int IN_DATA_W = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = 1 + IDX_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    // request kinds carried on tuser
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // search sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_COMPARE,
        ST_RESULT
    } sts_state_t;

    // table memory access from the sequencer
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [VAL_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } sts_mem_req_t;

endpackage

// ===== rtl/core/sts_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, registered
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/sts_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sts_ctrl
// Request sequencer: table writes and the halving search over the table RAM,
// with the result held in an output register.
// ----------------------------------------------------------------------------
module sts_ctrl
    import sts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CNT_W-1:0]      entry_count,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,     // req_type
    input  logic [IN_DATA_W-1:0]  s_tdata,     // write_index, write_value, search_key
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,     // found, position
    output sts_mem_req_t          mem_req,
    input  logic [VAL_W-1:0]      mem_rd_data
);

    sts_state_t state_reg, state_next;

    logic [ADDR_W-1:0]       left_reg, left_next;
    logic [ADDR_W-1:0]       right_reg, right_next;
    logic [ADDR_W-1:0]       mid_reg, mid_next;
    logic signed [VAL_W-1:0] key_reg, key_next;
    logic                    hit_reg, hit_next;
    logic [ADDR_W-1:0]       where_reg, where_next;
    logic                    m_tvalid_reg;
    logic                    m_found_reg;
    logic [IDX_W-1:0]        m_pos_reg;

    // request fields
    logic [IDX_W-1:0]        req_index;
    logic signed [VAL_W-1:0] req_value;
    logic signed [VAL_W-1:0] req_key;
    logic                    req_fire;
    logic                    out_free;
    logic                    load_out;

    // search bounds
    logic [CNT_W-1:0]        used_count;
    logic [ADDR_W-1:0]       mid_calc;
    logic [ADDR_W-1:0]       span;
    logic signed [VAL_W-1:0] probe;
    logic                    probe_eq;
    logic                    probe_lt;

    assign req_index = s_tdata[IDX_W-1:0];
    assign req_value = s_tdata[IDX_W+VAL_W-1:IDX_W];
    assign req_key   = s_tdata[IDX_W+2*VAL_W-1:IDX_W+VAL_W];
    assign req_fire  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // clamp the count to the table depth
    assign used_count = (entry_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                           : entry_count;

    // midpoint of the live range, rounded down
    assign span     = right_reg - left_reg;
    assign mid_calc = left_reg + (span >> 1);

    assign probe    = mem_rd_data;
    assign probe_eq = (probe == key_reg);
    assign probe_lt = (probe < key_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (s_tuser == REQ_SEARCH))
                begin
                    state_next = (used_count == '0) ? ST_RESULT : ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                state_next = ST_COMPARE;
            end
            ST_COMPARE:
            begin
                if (probe_eq)
                begin
                    state_next = ST_RESULT;
                end
                else if (probe_lt)
                begin
                    state_next = (mid_reg == right_reg) ? ST_RESULT : ST_PROBE;
                end
                else
                begin
                    state_next = (mid_reg == left_reg) ? ST_RESULT : ST_PROBE;
                end
            end
            ST_RESULT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready        = 1'b0;
        load_out        = 1'b0;
        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = req_index[ADDR_W-1:0];
        mem_req.wr_data = req_value;
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = mid_calc;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready      = 1'b1;
                // writes beyond the table are dropped
                mem_req.wr_en = s_tvalid && (s_tuser == REQ_WRITE)
                                && ({1'b0, req_index} < (IDX_W+1)'(TABLE_DEPTH));
            end
            ST_PROBE:
            begin
                mem_req.rd_en = 1'b1;
            end
            ST_COMPARE:
            begin
            end
            ST_RESULT:
            begin
                load_out = out_free;
            end
            default:
            begin
            end
        endcase
    end

    // search datapath
    always_comb
    begin
        left_next  = left_reg;
        right_next = right_reg;
        mid_next   = mid_reg;
        key_next   = key_reg;
        hit_next   = hit_reg;
        where_next = where_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (s_tuser == REQ_SEARCH))
                begin
                    key_next   = req_key;
                    left_next  = '0;
                    right_next = ADDR_W'(used_count - CNT_W'(1));
                    hit_next   = 1'b0;
                    where_next = '0;
                end
            end
            ST_PROBE:
            begin
                mid_next = mid_calc;
            end
            ST_COMPARE:
            begin
                if (probe_eq)
                begin
                    hit_next   = 1'b1;
                    where_next = mid_reg;
                end
                else if (probe_lt)
                begin
                    left_next = mid_reg + ADDR_W'(1);
                end
                else
                begin
                    right_next = mid_reg - ADDR_W'(1);
                end
            end
            ST_RESULT:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        left_reg  <= left_next;
        right_reg <= right_next;
        mid_reg   <= mid_next;
        key_reg   <= key_next;
        hit_reg   <= hit_next;
        where_reg <= where_next;
        if (load_out)
        begin
            m_found_reg <= hit_reg;
            m_pos_reg   <= IDX_W'(where_reg);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = OUT_DATA_W'({m_pos_reg, m_found_reg});

endmodule

// ===== rtl/core/sorted_table_binary_search.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search
// Table of ascending signed values with write requests and halving search.
// ----------------------------------------------------------------------------
//  channel   signals                          carries
//  s_*       s_tvalid s_tready s_tuser s_tdata write or search request
//  m_*       m_tvalid m_tready m_tdata        found flag and position
//  cfg_*     cfg_valid cfg_ready cfg_data     entry_count register
//
//  a write request gives no result
//  a search runs one halving step at a time (table RAM read, then compare)
//  and needs up to eleven steps with 1024 entries
//  the next request is taken as soon as the sequencer is idle; a finished
//  search waits until the output register has room for its result
//  reset clears entry_count and the sequencer; table contents stay undefined
//  until written
// ----------------------------------------------------------------------------
module sorted_table_binary_search
    import sts_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  s_tuser,     // req_type
    input  logic [IN_DATA_W-1:0]  s_tdata,     // write_index[9:0], write_value[41:10],
                                               // search_key[73:42]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,     // found[0], position[10:1]
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CNT_W-1:0]      cfg_data
);

    logic [CNT_W-1:0] entry_count_reg;
    sts_mem_req_t     mem_req;
    logic [VAL_W-1:0] mem_rd_data;

    // entry count register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            entry_count_reg <= cfg_data;
        end
    end

    // request sequencer
    sts_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_count (entry_count_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tuser     (s_tuser),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mem_req     (mem_req),
        .mem_rd_data (mem_rd_data)
    );

    // value table
    sts_ram #(
        .DEPTH  (TABLE_DEPTH),
        .DATA_W (VAL_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

endmodule
